@@ src/msc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// shared widths, types and helpers for the margin slope clamp pipeline
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int FRAC_SHIFT = 15;
    localparam int SLOPE_W    = 16;
    localparam int ELEV_W     = 25;
    localparam int DEPTH_W    = 20;
    localparam int LEN_W      = 20;
    localparam int SUM_W      = LEN_W + 1;
    localparam int VAL_W      = 34;
    localparam int PROD_W     = SLOPE_W + SUM_W + 1;
    localparam int CMP_W      = VAL_W + FRAC_SHIFT + 1;
    localparam int OUT_W      = 32;
    localparam int NUM_STEP   = 8;
    localparam int STEP_W     = 3;
    localparam int PIPE_DEPTH = NUM_STEP + 3;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic signed [SLOPE_W-1:0] SLOPE_ZERO = '0;
    localparam logic signed [SLOPE_W-1:0] SLOPE_TOP  = {1'b0, {(SLOPE_W-1){1'b1}}};

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CMP_W-1:0]  cmp_t;

    // register map, word index
    typedef enum logic [1:0] {
        REG_MIN_BED,
        REG_MAX_BED,
        REG_MIN_WATER,
        REG_MAX_WATER
    } reg_idx_t;

    // clamp steps in pipeline order; the code doubles as the product index
    typedef enum logic [STEP_W-1:0] {
        STEP_UP_BED_MIN,
        STEP_UP_BED_MAX,
        STEP_UP_WATER_MIN,
        STEP_UP_WATER_MAX,
        STEP_DN_BED_MIN,
        STEP_DN_BED_MAX,
        STEP_DN_WATER_MIN,
        STEP_DN_WATER_MAX
    } step_t;

    typedef struct packed {
        logic dn;
        logic water;
        logic use_max;
    } step_flags_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] min_bed;
        logic signed [SLOPE_W-1:0] max_bed;
        logic signed [SLOPE_W-1:0] min_water;
        logic signed [SLOPE_W-1:0] max_water;
        logic                      bed_max_en;
        logic                      water_max_en;
    } cfg_t;

    typedef struct packed {
        logic             up_edge;
        logic             dn_edge;
        val_t             elev;
        val_t             depth;
        val_t             d_elev;
        val_t             d_wl;
        val_t             u_elev;
        val_t             u_wl;
        logic [SUM_W-1:0] s_up;
        logic [SUM_W-1:0] s_dn;
    } front_t;

    typedef struct packed {
        logic                       up_edge;
        logic                       dn_edge;
        val_t                       elev;
        val_t                       depth;
        val_t                       d_elev;
        val_t                       d_wl;
        val_t                       u_elev;
        val_t                       u_wl;
        prod_t [NUM_STEP-1:0]       prod;
    } item_t;

    function automatic step_flags_t step_flags(step_t s);
        step_flags_t f;
        unique case (s)
            STEP_UP_BED_MIN:   f = '{dn: 1'b0, water: 1'b0, use_max: 1'b0};
            STEP_UP_BED_MAX:   f = '{dn: 1'b0, water: 1'b0, use_max: 1'b1};
            STEP_UP_WATER_MIN: f = '{dn: 1'b0, water: 1'b1, use_max: 1'b0};
            STEP_UP_WATER_MAX: f = '{dn: 1'b0, water: 1'b1, use_max: 1'b1};
            STEP_DN_BED_MIN:   f = '{dn: 1'b1, water: 1'b0, use_max: 1'b0};
            STEP_DN_BED_MAX:   f = '{dn: 1'b1, water: 1'b0, use_max: 1'b1};
            STEP_DN_WATER_MIN: f = '{dn: 1'b1, water: 1'b1, use_max: 1'b0};
            STEP_DN_WATER_MAX: f = '{dn: 1'b1, water: 1'b1, use_max: 1'b1};
            default:           f = '0;
        endcase
        return f;
    endfunction

    // saturate to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(val_t v);
        val_t hi;
        val_t lo;
        hi = val_t'({1'b0, {(OUT_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
        begin
            return OUT_W'(hi);
        end
        if (v < lo)
        begin
            return OUT_W'(lo);
        end
        return OUT_W'(v);
    endfunction

endpackage

@@ src/msc_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_regs
// apb slope limit registers and min/max order flags
// ----------------------------------------------------------------------------
module msc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msc_pkg::ADDR_W-1:0] paddr,
    input  logic [msc_pkg::DATA_W-1:0] pwdata,
    output logic [msc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output msc_pkg::cfg_t              cfg
);
    import msc_pkg::*;

    logic signed [SLOPE_W-1:0] min_bed_reg, min_bed_next;
    logic signed [SLOPE_W-1:0] max_bed_reg, max_bed_next;
    logic signed [SLOPE_W-1:0] min_water_reg, min_water_next;
    logic signed [SLOPE_W-1:0] max_water_reg, max_water_next;
    logic                      wr_en;
    reg_idx_t                  idx;
    logic signed [SLOPE_W-1:0] wdata;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wdata  = pwdata[SLOPE_W-1:0];

    always_comb
    begin
        min_bed_next   = min_bed_reg;
        max_bed_next   = max_bed_reg;
        min_water_next = min_water_reg;
        max_water_next = max_water_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MIN_BED:   min_bed_next   = wdata;
                REG_MAX_BED:   max_bed_next   = wdata;
                REG_MIN_WATER: min_water_next = wdata;
                REG_MAX_WATER: max_water_next = wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bed_reg   <= SLOPE_ZERO;
            max_bed_reg   <= SLOPE_TOP;
            min_water_reg <= SLOPE_ZERO;
            max_water_reg <= SLOPE_TOP;
        end
        else
        begin
            min_bed_reg   <= min_bed_next;
            max_bed_reg   <= max_bed_next;
            min_water_reg <= min_water_next;
            max_water_reg <= max_water_next;
        end
    end

    // readback, sign extended
    always_comb
    begin
        unique case (idx)
            REG_MIN_BED:   prdata = DATA_W'(min_bed_reg);
            REG_MAX_BED:   prdata = DATA_W'(max_bed_reg);
            REG_MIN_WATER: prdata = DATA_W'(min_water_reg);
            REG_MAX_WATER: prdata = DATA_W'(max_water_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.min_bed      = min_bed_reg;
        cfg.max_bed      = max_bed_reg;
        cfg.min_water    = min_water_reg;
        cfg.max_water    = max_water_reg;
        cfg.bed_max_en   = (min_bed_reg <= max_bed_reg);
        cfg.water_max_en = (min_water_reg <= max_water_reg);
    end

endmodule

@@ src/msc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_front
// input stage (widening, length sums, water levels) and slope product stage
// ----------------------------------------------------------------------------
module msc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msc_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              is_upstream_edge,
    input  logic                              is_downstream_edge,
    input  logic signed [msc_pkg::ELEV_W-1:0] cell_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       cell_depth,
    input  logic [msc_pkg::LEN_W-1:0]         cell_length,
    input  logic signed [msc_pkg::ELEV_W-1:0] down_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       down_depth,
    input  logic [msc_pkg::LEN_W-1:0]         down_length,
    input  logic signed [msc_pkg::ELEV_W-1:0] up_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       up_depth,
    input  logic [msc_pkg::LEN_W-1:0]         up_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output msc_pkg::item_t                    out_item
);
    import msc_pkg::*;

    front_t                s1_reg, s1_next;
    logic                  s1_valid_reg;
    logic                  s1_ready;
    item_t                 s2_reg, s2_next;
    logic                  s2_valid_reg;
    logic                  s2_ready;
    logic signed [SUM_W:0] s_up_s;
    logic signed [SUM_W:0] s_dn_s;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: widen and sum
    always_comb
    begin
        s1_next.up_edge = is_upstream_edge;
        s1_next.dn_edge = is_downstream_edge;
        s1_next.elev    = VAL_W'(cell_elevation);
        s1_next.depth   = VAL_W'(cell_depth);
        s1_next.d_elev  = VAL_W'(down_elevation);
        s1_next.d_wl    = VAL_W'(down_elevation) + VAL_W'(down_depth);
        s1_next.u_elev  = VAL_W'(up_elevation);
        s1_next.u_wl    = VAL_W'(up_elevation) + VAL_W'(up_depth);
        s1_next.s_up    = SUM_W'(cell_length) + SUM_W'(down_length);
        s1_next.s_dn    = SUM_W'(cell_length) + SUM_W'(up_length);
    end

    // stage 2: slope times summed length, one product per clamp step
    always_comb
    begin
        s_up_s = {1'b0, s1_reg.s_up};
        s_dn_s = {1'b0, s1_reg.s_dn};
        s2_next.up_edge = s1_reg.up_edge;
        s2_next.dn_edge = s1_reg.dn_edge;
        s2_next.elev    = s1_reg.elev;
        s2_next.depth   = s1_reg.depth;
        s2_next.d_elev  = s1_reg.d_elev;
        s2_next.d_wl    = s1_reg.d_wl;
        s2_next.u_elev  = s1_reg.u_elev;
        s2_next.u_wl    = s1_reg.u_wl;
        s2_next.prod[STEP_UP_BED_MIN]   = prod_t'(cfg.min_bed) * prod_t'(s_up_s);
        s2_next.prod[STEP_UP_BED_MAX]   = prod_t'(cfg.max_bed) * prod_t'(s_up_s);
        s2_next.prod[STEP_UP_WATER_MIN] = prod_t'(cfg.min_water) * prod_t'(s_up_s);
        s2_next.prod[STEP_UP_WATER_MAX] = prod_t'(cfg.max_water) * prod_t'(s_up_s);
        s2_next.prod[STEP_DN_BED_MIN]   = prod_t'(cfg.min_bed) * prod_t'(s_dn_s);
        s2_next.prod[STEP_DN_BED_MAX]   = prod_t'(cfg.max_bed) * prod_t'(s_dn_s);
        s2_next.prod[STEP_DN_WATER_MIN] = prod_t'(cfg.min_water) * prod_t'(s_dn_s);
        s2_next.prod[STEP_DN_WATER_MAX] = prod_t'(cfg.max_water) * prod_t'(s_dn_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

@@ src/msc_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_step
// one clamp step: compare slope against one limit, move elevation or depth
// ----------------------------------------------------------------------------
module msc_step (
    input  logic            clk,
    input  logic            rst_n,
    input  msc_pkg::step_t  step_sel,
    input  msc_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  msc_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output msc_pkg::item_t  out_item
);
    import msc_pkg::*;

    item_t       item_reg, item_next;
    logic        valid_reg;
    step_flags_t f;
    val_t        wl;
    val_t        dz;
    prod_t       p;
    val_t        off;
    cmp_t        lhs;
    cmp_t        rhs;
    logic        max_en;
    logic        at_margin;
    logic        hit;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        f         = step_flags(step_sel);
        p         = in_item.prod[step_sel];
        off       = val_t'(p >>> FRAC_SHIFT);
        wl        = in_item.elev + in_item.depth;
        max_en    = f.water ? cfg.water_max_en : cfg.bed_max_en;
        at_margin = f.dn ? in_item.dn_edge : in_item.up_edge;

        // slope numerator, oriented downhill
        if (!f.water)
        begin
            dz = f.dn ? (in_item.u_elev - in_item.elev) : (in_item.elev - in_item.d_elev);
        end
        else
        begin
            dz = f.dn ? (in_item.u_wl - wl) : (wl - in_item.d_wl);
        end

        // exact cross-multiplied compare
        lhs = cmp_t'(dz) <<< FRAC_SHIFT;
        rhs = cmp_t'(p);
        hit = f.use_max ? (max_en && (lhs > rhs)) : (lhs < rhs);

        item_next = in_item;
        if (at_margin && hit)
        begin
            if (!f.water)
            begin
                item_next.elev = f.dn ? (in_item.u_elev - off) : (in_item.d_elev + off);
            end
            else
            begin
                item_next.depth = f.dn ? (in_item.u_wl - off - in_item.elev)
                                       : (off + in_item.d_wl - in_item.elev);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ src/margin_slope_clamp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// margin_slope_clamp
// slope limiting of bed and water surface at the margins of a 1D river reach
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------
//  apb       psel/penable/pwrite       paddr, pwdata -> prdata (pready tied high)
//  in        in_valid / in_ready       margin flags, cell and neighbour geometry
//  out       out_valid / out_ready     new_elevation, new_depth
//
//  one transaction per cycle sustained while out_ready is high
//  registered path: input stage, slope product stage, eight clamp steps, output
//  the eight dependent clamp steps set the depth, one compare and add each
//  each stage has its own valid bit and ready ripples back, so a stall on out
//  holds only the full stages and empty stages keep taking transactions
//  reset clears the valid bits and loads the limit registers, no clearing pass
//
module margin_slope_clamp (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msc_pkg::ADDR_W-1:0]        paddr,
    input  logic [msc_pkg::DATA_W-1:0]        pwdata,
    output logic [msc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // input transactions
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              is_upstream_edge,
    input  logic                              is_downstream_edge,
    input  logic signed [msc_pkg::ELEV_W-1:0] cell_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       cell_depth,
    input  logic [msc_pkg::LEN_W-1:0]         cell_length,
    input  logic signed [msc_pkg::ELEV_W-1:0] down_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       down_depth,
    input  logic [msc_pkg::LEN_W-1:0]         down_length,
    input  logic signed [msc_pkg::ELEV_W-1:0] up_elevation,
    input  logic [msc_pkg::DEPTH_W-1:0]       up_depth,
    input  logic [msc_pkg::LEN_W-1:0]         up_length,
    // result transactions
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [msc_pkg::OUT_W-1:0]  new_elevation,
    output logic signed [msc_pkg::OUT_W-1:0]  new_depth
);
    import msc_pkg::*;

    cfg_t  cfg;

    // stage chain between front end and output register
    item_t stage_item  [0:NUM_STEP];
    logic  stage_valid [0:NUM_STEP];
    logic  stage_ready [0:NUM_STEP];

    // output register
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  new_elevation_reg;
    logic signed [OUT_W-1:0]  new_depth_reg;
    logic                     out_stage_ready;

    // transactions in flight, for checking
    logic [OCC_W-1:0]         occ_reg, occ_next;

    msc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // widen inputs, sum lengths, form the eight slope products
    msc_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .is_upstream_edge   (is_upstream_edge),
        .is_downstream_edge (is_downstream_edge),
        .cell_elevation     (cell_elevation),
        .cell_depth         (cell_depth),
        .cell_length        (cell_length),
        .down_elevation     (down_elevation),
        .down_depth         (down_depth),
        .down_length        (down_length),
        .up_elevation       (up_elevation),
        .up_depth           (up_depth),
        .up_length          (up_length),
        .out_valid          (stage_valid[0]),
        .out_ready          (stage_ready[0]),
        .out_item           (stage_item[0])
    );

    // upstream margin pass first (bed min, bed max, water min, water max),
    // then the downstream margin pass in the same order
    for (genvar g = 0; g < NUM_STEP; g++)
    begin : g_step
        msc_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_sel  (step_t'(STEP_W'(g))),
            .cfg       (cfg),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_item   (stage_item[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    // output register with saturation to 32 bits
    assign out_stage_ready         = !out_valid_reg || out_ready;
    assign stage_ready[NUM_STEP]   = out_stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= stage_valid[NUM_STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && stage_valid[NUM_STEP])
        begin
            new_elevation_reg <= sat_out(stage_item[NUM_STEP].elev);
            new_depth_reg     <= sat_out(stage_item[NUM_STEP].depth);
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_elevation = new_elevation_reg;
    assign new_depth     = new_depth_reg;

    // occupancy: accepted minus delivered transactions
    always_comb
    begin
        occ_next = occ_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // back pressure reaches the input only when every stage is full
    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && (occ_reg == OCC_W'(PIPE_DEPTH))))
        else $error("input stalled while the pipeline has an empty stage");

    // a result never appears without a transaction in flight
    a_no_phantom_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occ_reg != '0))
        else $error("result presented with no transaction in flight");

    // no more transactions in flight than stages
    a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule
